### design/kvs_pkg.sv
// Shared types, constants and register indexes for the knob velocity setpoint block.
package kvs_pkg;

    localparam int POT_W    = 8;
    localparam int TARGET_W = 16;
    localparam int STEP_W   = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int PROD_W   = POT_W + STEP_W;

    typedef logic [POT_W-1:0]      pot_t;
    typedef logic [TARGET_W-1:0]   target_t;
    typedef logic [STEP_W-1:0]     step_t;
    typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
    typedef logic [CFG_DATA_W-1:0] cfg_data_t;

    // Item kinds
    localparam logic KIND_CAPTURE = 1'b0;
    localparam logic KIND_TICK    = 1'b1;

    // Knob centre reading
    localparam pot_t POT_CENTER = 8'd128;

    // Configuration register indexes
    localparam cfg_idx_t CFG_DEAD_ZONE  = 3'd0;
    localparam cfg_idx_t CFG_STEP_MIN   = 3'd1;
    localparam cfg_idx_t CFG_STEP_MAX   = 3'd2;
    localparam cfg_idx_t CFG_TARGET_MIN = 3'd3;
    localparam cfg_idx_t CFG_TARGET_MAX = 3'd4;

    // Reset values of the configuration registers
    localparam pot_t    DEAD_ZONE_RST  = 8'd8;
    localparam step_t   STEP_MIN_RST   = 16'd1;
    localparam step_t   STEP_MAX_RST   = 16'd64;
    localparam target_t TARGET_MIN_RST = 16'd0;
    localparam target_t TARGET_MAX_RST = 16'hFFFF;

endpackage

### design/kvs_if.sv
// Handshake interfaces for the item, result and configuration channels.
interface kvs_item_if;
    logic              valid;
    logic              ready;
    logic              kind;
    kvs_pkg::pot_t     pot;
    kvs_pkg::target_t  target;

    modport source (output valid, output kind, output pot, output target, input ready);
    modport sink   (input valid, input kind, input pot, input target, output ready);
endinterface

interface kvs_result_if;
    logic              valid;
    logic              ready;
    kvs_pkg::target_t  new_target;
    logic              knob_live;

    modport source (output valid, output new_target, output knob_live, input ready);
    modport sink   (input valid, input new_target, input knob_live, output ready);
endinterface

interface kvs_cfg_if;
    logic                valid;
    logic                ready;
    kvs_pkg::cfg_idx_t   index;
    kvs_pkg::cfg_data_t  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### design/knob_velocity_setpoint_core.sv
// Knob velocity setpoint: turns a knob reading into a setpoint change per tick.
//
// Channels: item carries kind (capture or tick), pot and the present target;
// result returns new_target and knob_live, one result per item, in order.
// cfg writes dead_zone, step_min, step_max, target_min and target_max by
// index; it is always ready and should only be used while the block is idle.
//
// An item passes through the input register, then the result register, before
// its result is offered. Throughput: one item per cycle while the receiver does
// not stall, set by the single arithmetic pass (one 8x16 multiply, an add and a
// clamp) between the input and result registers.
//
// Reset clears the start position and the live latch and loads the register
// defaults. When the receiver stalls, the result register holds and the input
// register can still take one more item; item ready falls only when both are
// full and the result is not being taken.
module knob_velocity_setpoint_core
(
    input  logic                 clk,
    input  logic                 rst_n,
    kvs_cfg_if.sink              cfg,
    kvs_item_if.sink             item,
    kvs_result_if.source         result
);
    import kvs_pkg::*;

    // Configuration registers
    pot_t    dead_zone_reg;
    step_t   step_min_reg;
    step_t   step_max_reg;
    target_t target_min_reg;
    target_t target_max_reg;

    // Knob state
    pot_t    start_position_reg;
    pot_t    start_position_next;
    logic    live_flag_reg;
    logic    live_flag_next;

    // Input stage
    logic    in_valid_reg;
    logic    in_kind_reg;
    pot_t    in_pot_reg;
    target_t in_target_reg;

    // Result stage
    logic    out_valid_reg;
    target_t out_new_target_reg;
    logic    out_knob_live_reg;

    logic    advance;
    logic    item_xfer;

    pot_t              mag;
    pot_t              start_dist;
    logic              grow;
    step_t             span;
    logic [PROD_W-1:0] product;
    step_t             scaled;
    step_t             step_raw;
    step_t             step;
    logic              apply_step;
    logic signed [TARGET_W+1:0] nt;
    target_t           new_target;

    // Handshakes
    assign cfg.ready    = 1'b1;
    assign advance      = in_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready   = !in_valid_reg || advance;
    assign item_xfer    = item.valid && item.ready;

    assign result.valid      = out_valid_reg;
    assign result.new_target = out_new_target_reg;
    assign result.knob_live  = out_knob_live_reg;

    // Knob deflection from centre and from the start position
    always_comb
    begin
        mag        = (in_pot_reg >= POT_CENTER) ? (in_pot_reg - POT_CENTER)
                                                : (POT_CENTER - in_pot_reg);
        start_dist = (in_pot_reg >= start_position_reg) ? (in_pot_reg - start_position_reg)
                                                        : (start_position_reg - in_pot_reg);
    end

    // Step size, linear in deflection between step_min and step_max, zero inside the dead zone
    always_comb
    begin
        grow     = (step_max_reg >= step_min_reg);
        span     = grow ? (step_max_reg - step_min_reg) : (step_min_reg - step_max_reg);
        product  = PROD_W'(mag) * PROD_W'(span);
        scaled   = product[STEP_W+6:7];
        step_raw = grow ? (step_min_reg + scaled) : (step_min_reg - scaled);
        step     = (mag < dead_zone_reg) ? '0 : step_raw;
        apply_step = {step, 1'b0} > {1'b0, step_min_reg};
    end

    // Capture or live latch, else apply the signed step and clamp, upper bound first
    always_comb
    begin
        if (in_pot_reg >= POT_CENTER)
        begin
            nt = $signed({2'b00, in_target_reg}) + $signed({2'b00, step});
        end
        else
        begin
            nt = $signed({2'b00, in_target_reg}) - $signed({2'b00, step});
        end

        start_position_next = start_position_reg;
        live_flag_next      = live_flag_reg;
        new_target          = in_target_reg;

        if (in_kind_reg == KIND_CAPTURE)
        begin
            start_position_next = in_pot_reg;
        end
        else if (!live_flag_reg)
        begin
            if (start_dist > dead_zone_reg)
            begin
                live_flag_next = 1'b1;
            end
        end
        else if (apply_step)
        begin
            if (nt > $signed({2'b00, target_max_reg}))
            begin
                new_target = target_max_reg;
            end
            else if (nt < $signed({2'b00, target_min_reg}))
            begin
                new_target = target_min_reg;
            end
            else
            begin
                new_target = nt[TARGET_W-1:0];
            end
        end
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dead_zone_reg  <= DEAD_ZONE_RST;
            step_min_reg   <= STEP_MIN_RST;
            step_max_reg   <= STEP_MAX_RST;
            target_min_reg <= TARGET_MIN_RST;
            target_max_reg <= TARGET_MAX_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                CFG_DEAD_ZONE:  dead_zone_reg  <= cfg.data[POT_W-1:0];
                CFG_STEP_MIN:   step_min_reg   <= cfg.data[STEP_W-1:0];
                CFG_STEP_MAX:   step_max_reg   <= cfg.data[STEP_W-1:0];
                CFG_TARGET_MIN: target_min_reg <= cfg.data[TARGET_W-1:0];
                CFG_TARGET_MAX: target_max_reg <= cfg.data[TARGET_W-1:0];
                default:        ;
            endcase
        end
    end

    // Control state: valids, start position and live latch
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
            start_position_reg <= '0;
            live_flag_reg      <= 1'b0;
        end
        else
        begin
            if (item.ready)
            begin
                in_valid_reg <= item.valid;
            end
            if (advance)
            begin
                out_valid_reg      <= 1'b1;
                start_position_reg <= start_position_next;
                live_flag_reg      <= live_flag_next;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload: load the input stage on transfer, the result stage on advance
    always_ff @(posedge clk)
    begin
        if (item_xfer)
        begin
            in_kind_reg   <= item.kind;
            in_pot_reg    <= item.pot;
            in_target_reg <= item.target;
        end
        if (advance)
        begin
            out_new_target_reg <= new_target;
            out_knob_live_reg  <= live_flag_next;
        end
    end

endmodule

### sim/knob_velocity_setpoint_core_tb.sv
// Self-checking testbench for the knob velocity setpoint core: directed and random items.
`timescale 1ns / 1ps

module knob_velocity_setpoint_core_tb;
    import kvs_pkg::*;

    typedef struct {
        logic    kind;
        pot_t    pot;
        target_t target;
    } knob_item_t;

    typedef struct {
        target_t new_target;
        logic    live;
    } setpoint_t;

    logic clk = 1'b0;
    logic rst_n;

    kvs_item_if   item_ch ();
    kvs_result_if result_ch ();
    kvs_cfg_if    cfg_ch ();

    knob_velocity_setpoint_core i_dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_ch.sink),
        .item   (item_ch.sink),
        .result (result_ch.source)
    );

    // Predicted knob state and register copies
    pot_t    start_pos;
    logic    live_latched;
    pot_t    dead_zone_q;
    step_t   step_min_q;
    step_t   step_max_q;
    target_t target_lo_q;
    target_t target_hi_q;

    knob_item_t knob_items[$];
    setpoint_t  expected_setpoints[$];

    logic        item_moved = 1'b0;
    int unsigned burst_left = 1;
    int unsigned gap_left = 0;
    int unsigned hold_cycles = 0;
    int unsigned ready_mode = 0;
    int unsigned mode_left = 0;
    int unsigned ready_tick = 0;
    int          fault_count = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Work out the setpoint and live flag that one item leaves behind
    function automatic setpoint_t advance_setpoint(logic kind, pot_t pot, target_t tgt);
        int unsigned pot_u;
        int unsigned start_u;
        int unsigned mag;
        int unsigned lo;
        int unsigned hi;
        int unsigned stp;
        int          sum;
        setpoint_t   res;
        res.new_target = tgt;
        pot_u = 32'(pot);
        start_u = 32'(start_pos);
        lo = 32'(step_min_q);
        hi = 32'(step_max_q);
        if (kind == KIND_CAPTURE)
        begin
            start_pos = pot;
        end
        else if (!live_latched)
        begin
            if (((pot_u > start_u) ? pot_u - start_u : start_u - pot_u) > dead_zone_q)
                live_latched = 1'b1;
        end
        else
        begin
            mag = (pot_u >= 128) ? pot_u - 128 : 128 - pot_u;
            if (mag < dead_zone_q)
                stp = 0;
            else if (hi >= lo)
                stp = lo + ((mag * (hi - lo)) >> 7);
            else
                stp = lo - ((mag * (lo - hi)) >> 7);
            // Apply only a step large enough to matter; upper bound is tested first
            if (2 * stp > lo)
            begin
                sum = (pot_u >= 128) ? int'(tgt) + int'(stp) : int'(tgt) - int'(stp);
                if (sum > int'(target_hi_q))
                    res.new_target = target_hi_q;
                else if (sum < int'(target_lo_q))
                    res.new_target = target_lo_q;
                else
                    res.new_target = target_t'(sum);
            end
        end
        res.live = live_latched;
        return res;
    endfunction

    // Record each item transfer and predict its result
    always @(posedge clk)
    begin
        setpoint_t want;
        if (rst_n && item_ch.valid && item_ch.ready)
        begin
            want = advance_setpoint(item_ch.kind, item_ch.pot, item_ch.target);
            expected_setpoints.push_back(want);
            item_moved = 1'b1;
        end
    end

    // Compare each result transfer with the oldest prediction
    always @(posedge clk)
    begin
        setpoint_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (expected_setpoints.size() == 0)
            begin
                $error("unexpected result: new_target %0d, knob_live %0d",
                       result_ch.new_target, result_ch.knob_live);
                fault_count++;
            end
            else
            begin
                want = expected_setpoints.pop_front();
                if (result_ch.new_target !== want.new_target)
                begin
                    $error("new_target mismatch: expected %0d, actual %0d",
                           want.new_target, result_ch.new_target);
                    fault_count++;
                end
                if (result_ch.knob_live !== want.live)
                begin
                    $error("knob_live mismatch: expected %0d, actual %0d",
                           want.live, result_ch.knob_live);
                    fault_count++;
                end
            end
        end
    end

    // Offer items in bursts with random gaps; hold the item until its transfer
    always @(negedge clk)
    begin
        knob_item_t nxt;
        if (rst_n && (!item_ch.valid || item_moved))
        begin
            item_moved = 1'b0;
            if (gap_left > 0)
            begin
                gap_left--;
                item_ch.valid <= 1'b0;
            end
            else if (knob_items.size() > 0)
            begin
                nxt = knob_items.pop_front();
                item_ch.valid  <= 1'b1;
                item_ch.kind   <= nxt.kind;
                item_ch.pot    <= nxt.pot;
                item_ch.target <= nxt.target;
                if (burst_left > 1)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            else
                item_ch.valid <= 1'b0;
        end
    end

    // Stall the result side: long hold-off when asked, else a changing pattern
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles--;
            result_ch.ready <= 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                ready_mode = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 120);
            end
            mode_left--;
            ready_tick++;
            case (ready_mode)
                0: result_ch.ready <= 1'b1;
                1: result_ch.ready <= 1'($urandom_range(0, 1));
                2: result_ch.ready <= ($urandom_range(0, 3) == 0);
                default: result_ch.ready <= ready_tick[2];
            endcase
        end
    end

    task automatic queue_item(logic kind, pot_t pot, target_t tgt);
        knob_item_t it;
        it.kind = kind;
        it.pot = pot;
        it.target = tgt;
        knob_items.push_back(it);
    endtask

    // Write one register and mirror it in the predictor
    task automatic write_reg(cfg_idx_t idx, cfg_data_t val);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        case (idx)
            CFG_DEAD_ZONE:  dead_zone_q = val[7:0];
            CFG_STEP_MIN:   step_min_q = val;
            CFG_STEP_MAX:   step_max_q = val;
            CFG_TARGET_MIN: target_lo_q = val;
            CFG_TARGET_MAX: target_hi_q = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic set_config(cfg_data_t dz, cfg_data_t smin, cfg_data_t smax,
                              cfg_data_t tmin, cfg_data_t tmax);
        write_reg(CFG_DEAD_ZONE, dz);
        write_reg(CFG_STEP_MIN, smin);
        write_reg(CFG_STEP_MAX, smax);
        write_reg(CFG_TARGET_MIN, tmin);
        write_reg(CFG_TARGET_MAX, tmax);
    endtask

    // Wait until every item has gone through and every result has come back
    task automatic drain();
        while (knob_items.size() != 0 || item_ch.valid || expected_setpoints.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Pick a 16-bit value, biased low or high, with the extremes now and then
    function automatic cfg_data_t pick_word(logic lean_high);
        cfg_data_t v;
        case ($urandom_range(0, 7))
            0: v = 16'h0000;
            1: v = 16'hFFFF;
            2: v = 16'($urandom_range(0, 65535));
            default: v = lean_high ? 16'($urandom_range(61535, 65535))
                                   : 16'($urandom_range(0, 4000));
        endcase
        return v;
    endfunction

    task automatic load_random_settings();
        cfg_data_t dz;
        cfg_data_t smin;
        cfg_data_t smax;
        cfg_data_t tmin;
        cfg_data_t tmax;
        case ($urandom_range(0, 7))
            0: dz = 16'd0;
            1: dz = 16'd255;
            2: dz = 16'($urandom_range(129, 254));
            default: dz = 16'($urandom_range(1, 128));
        endcase
        // Upper byte of the dead zone write is ignored by the register
        if ($urandom_range(0, 1))
            dz[15:8] = 8'($urandom_range(0, 255));
        smin = ($urandom_range(0, 3) == 0) ? pick_word(1'b0) : 16'($urandom_range(0, 40));
        smax = ($urandom_range(0, 3) == 0) ? pick_word(1'b1) : 16'($urandom_range(0, 2000));
        tmin = ($urandom_range(0, 7) == 0) ? pick_word(1'b1) : pick_word(1'b0);
        tmax = ($urandom_range(0, 7) == 0) ? pick_word(1'b0) : pick_word(1'b1);
        set_config(dz, smin, smax, tmin, tmax);
    endtask

    function automatic knob_item_t random_item();
        knob_item_t  it;
        int unsigned w;
        int          off;
        it.kind = ($urandom_range(0, 3) == 0) ? KIND_CAPTURE : KIND_TICK;
        w = (dead_zone_q + 2 > 127) ? 127 : dead_zone_q + 2;
        case ($urandom_range(0, 3))
            0:
            begin
                off = int'($urandom_range(0, 2 * w)) - int'(w);
                it.pot = pot_t'(128 + off);
            end
            1:
            begin
                case ($urandom_range(0, 3))
                    0: it.pot = 8'd0;
                    1: it.pot = 8'd255;
                    2: it.pot = POT_CENTER;
                    default: it.pot = $urandom_range(1, 2) == 1 ? 8'd1 : 8'd254;
                endcase
            end
            default: it.pot = pot_t'($urandom_range(0, 255));
        endcase
        case ($urandom_range(0, 9))
            0: it.target = target_t'($urandom_range(0, 300));
            1: it.target = target_t'($urandom_range(65235, 65535));
            2: it.target = target_t'(target_lo_q + $urandom_range(0, 64));
            3: it.target = target_t'(target_hi_q - $urandom_range(0, 64));
            default: it.target = target_t'($urandom_range(0, 65535));
        endcase
        return it;
    endfunction

    // Time limit
    initial
    begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

    // Stimulus sequence
    initial
    begin
        rst_n = 1'b0;
        item_ch.valid = 1'b0;
        item_ch.kind = KIND_CAPTURE;
        item_ch.pot = '0;
        item_ch.target = '0;
        result_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = CFG_DEAD_ZONE;
        cfg_ch.data = '0;
        start_pos = '0;
        live_latched = 1'b0;
        dead_zone_q = DEAD_ZONE_RST;
        step_min_q = STEP_MIN_RST;
        step_max_q = STEP_MAX_RST;
        target_lo_q = TARGET_MIN_RST;
        target_hi_q = TARGET_MAX_RST;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Knob held inside the dead zone around each start position
        queue_item(KIND_CAPTURE, POT_CENTER, 16'd500);
        queue_item(KIND_TICK, 8'd136, 16'd500);
        queue_item(KIND_TICK, 8'd120, 16'd0);
        queue_item(KIND_CAPTURE, 8'd0, 16'hFFFF);
        queue_item(KIND_TICK, 8'd8, 16'd1234);
        queue_item(KIND_CAPTURE, 8'd255, 16'd42);
        queue_item(KIND_TICK, 8'd247, 16'd42);
        // One past the dead zone sets the latch without a step
        queue_item(KIND_TICK, 8'd246, 16'd42);
        // Live: centre, edge of the dead zone, full deflection and clamping
        queue_item(KIND_TICK, POT_CENTER, 16'd1000);
        queue_item(KIND_TICK, 8'd135, 16'd1000);
        queue_item(KIND_TICK, 8'd136, 16'd1000);
        queue_item(KIND_TICK, 8'd255, 16'hFFFF);
        queue_item(KIND_TICK, 8'd0, 16'd0);
        queue_item(KIND_TICK, 8'd0, 16'd1000);
        // Capture while live keeps the latch
        queue_item(KIND_CAPTURE, 8'd77, 16'd12345);
        drain();

        // Shrinking step, inverted clamp range, no dead zone
        set_config(16'd0, 16'd1000, 16'd10, 16'd50000, 16'd1000);
        queue_item(KIND_TICK, POT_CENTER, 16'd3000);
        queue_item(KIND_TICK, 8'd0, 16'd60000);
        queue_item(KIND_TICK, 8'd64, 16'd0);
        drain();

        // Dead zone too wide to ever step
        set_config(16'd255, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF);
        queue_item(KIND_TICK, 8'd255, 16'd100);
        queue_item(KIND_TICK, 8'd0, 16'd100);
        drain();

        // Widest step range with full-scale clamping
        set_config(16'd0, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF);
        queue_item(KIND_TICK, 8'd255, 16'd100);
        queue_item(KIND_TICK, 8'd0, 16'hFFFF);
        queue_item(KIND_TICK, POT_CENTER, 16'd777);
        drain();

        // Random phases, each under its own settings
        for (int phase = 0; phase < 7; phase++)
        begin
            load_random_settings();
            if (phase == 1 || phase == 4)
                hold_cycles = 80;
            repeat (250) knob_items.push_back(random_item());
            drain();
        end

        repeat (10) @(negedge clk);
        if (fault_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
